/* design/ldfw_pkg.sv */
package ldfw_pkg;

  // coordinate and datapath widths
  localparam int CoordW = 21;
  localparam int DiffW  = 22;
  localparam int ProdW  = 44;
  localparam int LenW   = 44;
  localparam int NumW   = 88;
  localparam int QuoW   = 44;
  localparam int RootW  = 22;
  localparam int RadW   = 22;
  localparam int FracW  = 16;
  localparam int WgtW   = 17;
  localparam int WQuoW  = 17;
  localparam int PackW  = 63;

  localparam logic [WgtW-1:0] WgtOne = 17'd65536;

  // configuration register indexes
  localparam logic [2:0] CfgLineStart = 3'd0;
  localparam logic [2:0] CfgLineEnd   = 3'd1;
  localparam logic [2:0] CfgInner     = 3'd2;
  localparam logic [2:0] CfgOuter     = 3'd3;
  localparam logic [2:0] CfgInfinite  = 3'd4;

  localparam logic [RadW-1:0] OuterReset = 22'd25600;

endpackage

/* design/ldfw_if.sv */
// vertex word channel
interface ldfw_vtx_if
  import ldfw_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [CoordW-1:0] vertex_x;
  logic signed [CoordW-1:0] vertex_y;
  logic signed [CoordW-1:0] vertex_z;

  modport source (output valid, vertex_x, vertex_y, vertex_z, input ready);
  modport sink (input valid, vertex_x, vertex_y, vertex_z, output ready);
endinterface

// weight word channel
interface ldfw_wgt_if
  import ldfw_pkg::*;
();
  logic            valid;
  logic            ready;
  logic [WgtW-1:0] weight;

  modport source (output valid, weight, input ready);
  modport sink (input valid, weight, output ready);
endinterface

/* design/line_distance_falloff_weight.sv */
// Distance falloff weight of a vertex against a configured line or segment.
// Each vertex word gives one weight word, unsigned Q1.16, in order. The block
// is a 92-stage pipeline that takes a new vertex every clock while the output
// is not stalled: 7 stages of products and sums, a 44-stage squared-distance
// divider, a 22-stage square root, one stage of radius checks, a 17-stage
// weight divider and the output register. A stall at the output freezes the
// whole pipeline, with no words lost. Write the configuration registers only
// while no vertex is in flight.
module line_distance_falloff_weight
  import ldfw_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  ldfw_vtx_if.sink         in_vtx,
  ldfw_wgt_if.source       out_wgt,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [PackW-1:0] cfg_data
);

  // configuration registers
  logic [PackW-1:0] line_start_r;
  logic [PackW-1:0] line_end_r;
  logic [RadW-1:0]  inner_r;
  logic [RadW-1:0]  outer_r;
  logic             inf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_start_r <= '0;
      line_end_r   <= '0;
      inner_r      <= '0;
      outer_r      <= OuterReset;
      inf_r        <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CfgLineStart: line_start_r <= cfg_data;
        CfgLineEnd:   line_end_r   <= cfg_data;
        CfgInner:     inner_r      <= cfg_data[RadW-1:0];
        CfgOuter:     outer_r      <= cfg_data[RadW-1:0];
        CfgInfinite:  inf_r        <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // global advance
  logic en;
  logic out_valid_r;
  logic [WgtW-1:0] out_weight_r;

  assign en           = !out_valid_r || out_wgt.ready;
  assign in_vtx.ready = en;

  // squared distance as a ratio
  logic            fr_valid;
  logic [NumW-1:0] fr_num;
  logic [LenW-1:0] fr_den;

  ldfw_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (in_vtx.valid),
    .vx         (in_vtx.vertex_x),
    .vy         (in_vtx.vertex_y),
    .vz         (in_vtx.vertex_z),
    .line_start (line_start_r),
    .line_end   (line_end_r),
    .infinite   (inf_r),
    .out_valid  (fr_valid),
    .out_num    (fr_num),
    .out_den    (fr_den)
  );

  // floor of the ratio
  logic            dq_valid;
  logic [QuoW-1:0] dq_quo;

  ldfw_div #(.DW(LenW), .QW(QuoW)) u_dist_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (fr_valid),
    .in_num    (fr_num),
    .in_den    (fr_den),
    .out_valid (dq_valid),
    .out_quo   (dq_quo)
  );

  // distance
  logic             sr_valid;
  logic [RootW-1:0] dist_val;

  ldfw_sqrt #(.RW(RootW)) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (dq_valid),
    .in_val    (dq_quo),
    .out_valid (sr_valid),
    .out_root  (dist_val)
  );

  // radius checks; saturated cases are folded into the divider operands
  localparam int WNumW = RadW + WQuoW;
  logic             wv_r;
  logic [WNumW-1:0] wnum_r;
  logic [RadW-1:0]  wden_r;
  logic             full_sel;
  logic             no_sel;
  logic [RadW-1:0]  excess;
  logic [RadW-1:0]  span;

  always_comb begin
    full_sel = (dist_val <= inner_r);
    no_sel   = !full_sel && ((outer_r <= inner_r) || (dist_val >= outer_r));
    excess   = dist_val - inner_r;
    span     = outer_r - inner_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (full_sel) begin
        wnum_r <= '0;
        wden_r <= RadW'(1);
      end else if (no_sel) begin
        wnum_r <= WNumW'(WgtOne);
        wden_r <= RadW'(1);
      end else begin
        wnum_r <= {1'b0, excess, {FracW{1'b0}}};
        wden_r <= span;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wv_r <= 1'b0;
    end else if (en) begin
      wv_r <= sr_valid;
    end
  end

  // falloff fraction
  logic             wq_valid;
  logic [WQuoW-1:0] wq_quo;

  ldfw_div #(.DW(RadW), .QW(WQuoW)) u_wgt_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (wv_r),
    .in_num    (wnum_r),
    .in_den    (wden_r),
    .out_valid (wq_valid),
    .out_quo   (wq_quo)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= wq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_weight_r <= WgtOne - wq_quo;
    end
  end

  assign out_wgt.valid  = out_valid_r;
  assign out_wgt.weight = out_weight_r;

`ifndef ASSERT_OFF
  a_wgt_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_weight_r <= WgtOne))
    else $error("weight above one");

  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_wgt.ready) |-> !in_vtx.ready)
    else $error("input taken while output stalled");

  a_wdiv_range: assert property (@(posedge clk) disable iff (!rst_n)
    wq_valid |-> (wq_quo <= WQuoW'(WgtOne)))
    else $error("falloff quotient out of range");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("output valid after reset");
`endif

endmodule

/* design/ldfw_front.sv */
// Seven stages: differences, products, sums, case select, partial squares,
// component squares, final numerator/denominator.
module ldfw_front
  import ldfw_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic signed [CoordW-1:0] vx,
  input  logic signed [CoordW-1:0] vy,
  input  logic signed [CoordW-1:0] vz,
  input  logic [PackW-1:0]         line_start,
  input  logic [PackW-1:0]         line_end,
  input  logic                     infinite,
  output logic                     out_valid,
  output logic [NumW-1:0]          out_num,
  output logic [LenW-1:0]          out_den
);

  logic signed [CoordW-1:0] s [3];
  logic signed [CoordW-1:0] e [3];
  logic signed [CoordW-1:0] p [3];

  assign p[0] = vx;
  assign p[1] = vy;
  assign p[2] = vz;

  for (genvar i = 0; i < 3; i++) begin : g_unpack
    assign s[i] = $signed(line_start[CoordW*i +: CoordW]);
    assign e[i] = $signed(line_end[CoordW*i +: CoordW]);
  end

  logic [6:0] vld_r;

  // stage 1: d = E-S, v = P-S, w = P-E
  logic signed [DiffW-1:0] d_r [3];
  logic signed [DiffW-1:0] v_r [3];
  logic signed [DiffW-1:0] w_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        d_r[i] <= DiffW'(e[i]) - DiffW'(s[i]);
        v_r[i] <= DiffW'(p[i]) - DiffW'(s[i]);
        w_r[i] <= DiffW'(p[i]) - DiffW'(e[i]);
      end
    end
  end

  // stage 2: all 22x22 products
  logic signed [ProdW-1:0] ca_r [3];
  logic signed [ProdW-1:0] cb_r [3];
  logic signed [ProdW-1:0] dd_r [3];
  logic signed [ProdW-1:0] dv_r [3];
  logic signed [ProdW-1:0] vv_r [3];
  logic signed [ProdW-1:0] ww_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      ca_r[0] <= d_r[1] * v_r[2];
      cb_r[0] <= d_r[2] * v_r[1];
      ca_r[1] <= d_r[2] * v_r[0];
      cb_r[1] <= d_r[0] * v_r[2];
      ca_r[2] <= d_r[0] * v_r[1];
      cb_r[2] <= d_r[1] * v_r[0];
      for (int i = 0; i < 3; i++) begin
        dd_r[i] <= d_r[i] * d_r[i];
        dv_r[i] <= d_r[i] * v_r[i];
        vv_r[i] <= v_r[i] * v_r[i];
        ww_r[i] <= w_r[i] * w_r[i];
      end
    end
  end

  // stage 3: cross product, dot, lengths
  logic signed [ProdW:0]   cx_r [3];
  logic signed [ProdW+1:0] dot_r;
  logic [LenW-1:0]         len2_r;
  logic [LenW-1:0]         sqv_r;
  logic [LenW-1:0]         sqw_r;
  logic signed [ProdW+1:0] len2_sum;
  logic signed [ProdW+1:0] sqv_sum;
  logic signed [ProdW+1:0] sqw_sum;

  always_comb begin
    len2_sum = (ProdW+2)'(dd_r[0]) + (ProdW+2)'(dd_r[1]) + (ProdW+2)'(dd_r[2]);
    sqv_sum  = (ProdW+2)'(vv_r[0]) + (ProdW+2)'(vv_r[1]) + (ProdW+2)'(vv_r[2]);
    sqw_sum  = (ProdW+2)'(ww_r[0]) + (ProdW+2)'(ww_r[1]) + (ProdW+2)'(ww_r[2]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        cx_r[i] <= (ProdW+1)'(ca_r[i]) - (ProdW+1)'(cb_r[i]);
      end
      dot_r  <= (ProdW+2)'(dv_r[0]) + (ProdW+2)'(dv_r[1]) + (ProdW+2)'(dv_r[2]);
      len2_r <= len2_sum[LenW-1:0];
      sqv_r  <= sqv_sum[LenW-1:0];
      sqw_r  <= sqw_sum[LenW-1:0];
    end
  end

  // stage 4: closest point case, cross magnitudes
  logic            seg_start;
  logic            seg_end;
  logic            inter_r4;
  logic [LenW-1:0] sq_r4;
  logic [LenW-1:0] len2_r4;
  logic [ProdW-1:0] mag_r [3];
  logic signed [ProdW:0] neg [3];

  always_comb begin
    seg_start = (len2_r == '0) || (!infinite && (dot_r <= 46'sd0));
    seg_end   = !infinite && (dot_r >= $signed({2'b00, len2_r}));
    for (int i = 0; i < 3; i++) begin
      neg[i] = -cx_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      inter_r4 <= !seg_start && !seg_end;
      sq_r4    <= seg_start ? sqv_r : sqw_r;
      len2_r4  <= len2_r;
      for (int i = 0; i < 3; i++) begin
        mag_r[i] <= cx_r[i][ProdW] ? neg[i][ProdW-1:0] : cx_r[i][ProdW-1:0];
      end
    end
  end

  // stage 5: partial products of the 44-bit squares
  localparam int HalfW = ProdW / 2;
  logic [ProdW-1:0] hh_r [3];
  logic [ProdW-1:0] hl_r [3];
  logic [ProdW-1:0] ll_r [3];
  logic            inter_r5;
  logic [LenW-1:0] sq_r5;
  logic [LenW-1:0] len2_r5;

  always_ff @(posedge clk) begin
    if (en) begin
      inter_r5 <= inter_r4;
      sq_r5    <= sq_r4;
      len2_r5  <= len2_r4;
      for (int i = 0; i < 3; i++) begin
        hh_r[i] <= mag_r[i][ProdW-1:HalfW] * mag_r[i][ProdW-1:HalfW];
        hl_r[i] <= mag_r[i][ProdW-1:HalfW] * mag_r[i][HalfW-1:0];
        ll_r[i] <= mag_r[i][HalfW-1:0] * mag_r[i][HalfW-1:0];
      end
    end
  end

  // stage 6: assemble component squares
  logic [NumW-1:0] c2_r [3];
  logic            inter_r6;
  logic [LenW-1:0] sq_r6;
  logic [LenW-1:0] len2_r6;

  always_ff @(posedge clk) begin
    if (en) begin
      inter_r6 <= inter_r5;
      sq_r6    <= sq_r5;
      len2_r6  <= len2_r5;
      for (int i = 0; i < 3; i++) begin
        c2_r[i] <= (NumW'(hh_r[i]) << ProdW) + (NumW'(hl_r[i]) << (HalfW + 1))
                 + NumW'(ll_r[i]);
      end
    end
  end

  // stage 7: numerator and denominator of squared distance
  always_ff @(posedge clk) begin
    if (en) begin
      if (inter_r6) begin
        out_num <= c2_r[0] + c2_r[1] + c2_r[2];
        out_den <= len2_r6;
      end else begin
        out_num <= NumW'(sq_r6);
        out_den <= LenW'(1);
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[5:0], in_valid};
    end
  end

  assign out_valid = vld_r[6];

endmodule

/* design/ldfw_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
// The caller guarantees the quotient fits in QW bits.
module ldfw_div
  import ldfw_pkg::*;
#(
  parameter int DW = LenW,
  parameter int QW = QuoW
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  logic [DW+QW-1:0] in_num,
  input  logic [DW-1:0]   in_den,
  output logic            out_valid,
  output logic [QW-1:0]   out_quo
);

  localparam int NW = DW + QW;

  logic [DW-1:0] rem_r [QW];
  logic [QW-1:0] low_r [QW];
  logic [QW-1:0] quo_r [QW];
  logic [DW-1:0] den_r [QW];
  logic [QW-1:0] vld_r;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW-1:0] rs;
    logic [QW-1:0] ls;
    logic [QW-1:0] qs;
    logic [DW-1:0] ds;
    logic          vs;
    logic [DW:0]   t;
    logic [DW:0]   diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign rs = in_num[NW-1:QW];
      assign ls = in_num[QW-1:0];
      assign qs = '0;
      assign ds = in_den;
      assign vs = in_valid;
    end else begin : g_next
      assign rs = rem_r[k-1];
      assign ls = low_r[k-1];
      assign qs = quo_r[k-1];
      assign ds = den_r[k-1];
      assign vs = vld_r[k-1];
    end

    // shift in next numerator bit, subtract when it fits
    assign t    = {rs, ls[QW-1]};
    assign diff = t - {1'b0, ds};
    assign ge   = (t >= {1'b0, ds});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? diff[DW-1:0] : t[DW-1:0];
        low_r[k] <= {ls[QW-2:0], 1'b0};
        quo_r[k] <= {qs[QW-2:0], ge};
        den_r[k] <= ds;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vs;
      end
    end
  end

  assign out_valid = vld_r[QW-1];
  assign out_quo   = quo_r[QW-1];

endmodule

/* design/ldfw_sqrt.sv */
// Pipelined digit-by-digit integer square root, one root bit per stage.
module ldfw_sqrt
  import ldfw_pkg::*;
#(
  parameter int RW = RootW
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  logic [2*RW-1:0] in_val,
  output logic            out_valid,
  output logic [RW-1:0]   out_root
);

  logic [2*RW-1:0] val_r  [RW];
  logic [RW+1:0]   rem_r  [RW];
  logic [RW-1:0]   root_r [RW];
  logic [RW-1:0]   vld_r;

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic [2*RW-1:0] vs;
    logic [RW+1:0]   rs;
    logic [RW-1:0]   qs;
    logic            ok;
    logic [RW+1:0]   t;
    logic [RW+1:0]   trial;
    logic            ge;

    if (k == 0) begin : g_first
      assign vs = in_val;
      assign rs = '0;
      assign qs = '0;
      assign ok = in_valid;
    end else begin : g_next
      assign vs = val_r[k-1];
      assign rs = rem_r[k-1];
      assign qs = root_r[k-1];
      assign ok = vld_r[k-1];
    end

    // bring down two bits, try root*4+1
    assign t     = {rs[RW-1:0], vs[2*RW-1:2*RW-2]};
    assign trial = {qs, 2'b01};
    assign ge    = (t >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        val_r[k]  <= {vs[2*RW-3:0], 2'b00};
        rem_r[k]  <= ge ? (t - trial) : t;
        root_r[k] <= {qs[RW-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= ok;
      end
    end
  end

  assign out_valid = vld_r[RW-1];
  assign out_root  = root_r[RW-1];

endmodule
